>>> rtl/core/tet_pkg.sv
// shared types and constants for the timer expiry table
// no dependencies; imported by every module of the block but the ram
package tet_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int TIME_W   = 32;
    localparam int TASK_W   = 8;
    localparam int SIG_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int TTYPE_W  = 2;
    localparam int RKIND_W  = 2;

    // packed stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic {
        IN_TICK = 1'b0,
        IN_ADD  = 1'b1
    } t_in_kind;

    typedef enum logic [TTYPE_W-1:0] {
        TK_TASK_PERIODIC = 2'd0,
        TK_TASK_SINGLE   = 2'd1,
        TK_SYS_SINGLE    = 2'd2,
        TK_SYS_PERIODIC  = 2'd3
    } t_timer_kind;

    typedef enum logic [RKIND_W-1:0] {
        RK_ADD   = 2'd0,
        RK_TASK  = 2'd1,
        RK_FLAGS = 2'd2
    } t_result_kind;

    // one timer slot as held in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] period;
        t_timer_kind       ttype;
        logic [TASK_W-1:0] task_id;
        logic [SIG_W-1:0]  sig;
    } t_slot_rec;

    localparam int REC_W = $bits(t_slot_rec);

    // request to the remainder unit
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

endpackage

>>> rtl/core/tet_ram.sv
// generic simple dual-port ram, one write and one read port, registered read
// no dependencies
module tet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/tet_rem_div.sv
// bit-serial remainder unit, one quotient bit per cycle
// depends on tet_pkg
module tet_rem_div
    import tet_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [TIME_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(TIME_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_dvd;
    logic [TIME_W-1:0] r_dsr;

    logic [TIME_W:0]   w_shift;
    logic [TIME_W:0]   w_diff;
    logic              w_ge;
    logic [TIME_W-1:0] w_rem_next;

    // restoring step: shift in next dividend bit, subtract when it fits
    always_comb begin
        w_shift    = {r_rem, r_dvd[TIME_W-1]};
        w_diff     = w_shift - {1'b0, r_dsr};
        w_ge       = (w_shift >= {1'b0, r_dsr});
        w_rem_next = w_ge ? w_diff[TIME_W-1:0] : w_shift[TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/timer_expiry_table_unit.sv
// timer expiry table: slot memory, valid bits and the scan sequencer
// depends on tet_pkg, tet_ram and tet_rem_div
//
//  channel  | dir | tdata fields (lsb first)                         | tuser       | tlast
//  ---------+-----+--------------------------------------------------+-------------+-----------
//  s_axis   | in  | timer_kind, first_delay, period, task_id,        | kind        | -
//           |     | signal_bits, zero pad                            |             |
//  m_axis   | out | slot, table_full, target_task, raised_bits, pad  | result_kind | last
//
// add: accept, then probe slot by slot up to the first free slot (every
// slot when full); tick: accept, check each slot's valid bit, and for an
// occupied slot a registered memory read and an evaluation, the bit-serial
// remainder for a periodic slot a full period or more behind, and at the
// end the flags transaction; a stalled result holds the sequencer
// reset is synchronous, active low: state, counter, valid bits and handshake only
module timer_expiry_table_unit
    import tet_pkg::*;
#(
    parameter int TIMER_SLOTS = SLOTS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] timer_kind, [33:2] first_delay, [65:34] period,
    // [73:66] task_id, [105:74] signal_bits, [111:106] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] kind
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] slot, [4] table_full, [12:5] target_task, [44:13] raised_bits,
    // [47:45] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] result_kind
    output logic [RKIND_W-1:0]    m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int IDX_W = $clog2(TIMER_SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMER_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_EVAL,
        S_DIV,
        S_FLAGS
    } t_state;

    // control state
    t_state                 r_state, n_state;
    logic [TIMER_SLOTS-1:0] r_valid, n_valid;
    logic [TIME_W-1:0]      r_tick, n_tick;
    logic                   r_m_valid, n_m_valid;

    // working registers
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [SIG_W-1:0]       r_flags, n_flags;
    t_slot_rec              r_in, n_in;

    // result payload
    t_result_kind           r_m_kind, n_m_kind;
    logic [SLOT_W-1:0]      r_m_slot, n_m_slot;
    logic                   r_m_full, n_m_full;
    logic [TASK_W-1:0]      r_m_task, n_m_task;
    logic [SIG_W-1:0]       r_m_bits, n_m_bits;
    logic                   r_m_last, n_m_last;

    // slot memory and remainder unit hookup
    logic                   w_ram_we;
    logic                   w_ram_re;
    t_slot_rec              w_ram_wdata;
    t_slot_rec              w_rec;
    logic [REC_W-1:0]       w_ram_rdata;
    t_div_req               w_div_req;
    logic                   w_div_done;
    logic [TIME_W-1:0]      w_div_rem;

    // helpers
    logic                   w_out_free;
    logic                   w_is_last;
    logic [SLOT_W-1:0]      w_slot_out;
    logic [31:0]            w_idx_ext;
    logic [TIME_W:0]        w_add_sum;
    logic [TIME_W-1:0]      w_per_eff;
    logic [TIME_W-1:0]      w_lag;
    logic [TIME_W:0]        w_fast_sum;
    logic [TIME_W:0]        w_slow_sum;
    logic                   w_is_task;
    logic                   w_is_periodic;

    function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W:0] v);
        return v[TIME_W] ? TIME_MAX : v[TIME_W-1:0];
    endfunction

    tet_ram #(
        .WIDTH (REC_W),
        .DEPTH (TIMER_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    tet_rem_div u_rem_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_rem   (w_div_rem)
    );

    assign w_rec      = t_slot_rec'(w_ram_rdata);
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_is_last  = (r_idx == IDX_LAST);
    assign w_idx_ext  = 32'(r_idx);
    assign w_slot_out = w_idx_ext[SLOT_W-1:0];

    // due-time arithmetic on the incoming add and on the slot just read
    always_comb begin
        w_add_sum     = {1'b0, r_tick} + {1'b0, s_axis_tdata[33:2]};
        w_per_eff     = (w_rec.period == '0) ? TIME_W'(1) : w_rec.period;
        w_lag         = r_tick - w_rec.due;
        // lag below one period: next due is simply due + period
        w_fast_sum    = {1'b0, w_rec.due} + {1'b0, w_per_eff};
        // otherwise now - (lag mod period) + period
        w_slow_sum    = {1'b0, r_tick} - {1'b0, w_div_rem} + {1'b0, w_per_eff};
        w_is_task     = (w_rec.ttype == TK_TASK_PERIODIC) || (w_rec.ttype == TK_TASK_SINGLE);
        w_is_periodic = (w_rec.ttype == TK_TASK_PERIODIC) || (w_rec.ttype == TK_SYS_PERIODIC);
    end

    always_comb begin
        logic v_adv;
        v_adv = 1'b0;

        n_state   = r_state;
        n_valid   = r_valid;
        n_tick    = r_tick;
        n_idx     = r_idx;
        n_flags   = r_flags;
        n_in      = r_in;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_kind  = r_m_kind;
        n_m_slot  = r_m_slot;
        n_m_full  = r_m_full;
        n_m_task  = r_m_task;
        n_m_bits  = r_m_bits;
        n_m_last  = r_m_last;

        w_ram_we           = 1'b0;
        w_ram_re           = 1'b0;
        w_ram_wdata        = w_rec;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_lag;
        w_div_req.divisor  = w_per_eff;

        s_axis_tready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_idx = '0;
                    if (t_in_kind'(s_axis_tuser) == IN_ADD) begin
                        n_in.ttype   = t_timer_kind'(s_axis_tdata[1:0]);
                        n_in.due     = sat_time(w_add_sum);
                        n_in.period  = s_axis_tdata[65:34];
                        n_in.task_id = s_axis_tdata[73:66];
                        n_in.sig     = s_axis_tdata[105:74];
                        n_state      = S_ADD;
                    end else begin
                        n_tick  = (r_tick == TIME_MAX) ? r_tick : r_tick + 1'b1;
                        n_flags = '0;
                        n_state = S_SCAN;
                    end
                end
            end

            S_ADD: begin
                if (!r_valid[r_idx]) begin
                    if (w_out_free) begin
                        w_ram_we       = 1'b1;
                        w_ram_wdata    = r_in;
                        n_valid[r_idx] = 1'b1;
                        n_m_valid      = 1'b1;
                        n_m_kind       = RK_ADD;
                        n_m_slot       = w_slot_out;
                        n_m_full       = 1'b0;
                        n_m_task       = '0;
                        n_m_bits       = '0;
                        n_m_last       = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (w_is_last) begin
                    if (w_out_free) begin
                        n_m_valid = 1'b1;
                        n_m_kind  = RK_ADD;
                        n_m_slot  = '0;
                        n_m_full  = 1'b1;
                        n_m_task  = '0;
                        n_m_bits  = '0;
                        n_m_last  = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_SCAN: begin
                if (r_valid[r_idx]) begin
                    w_ram_re = 1'b1;
                    n_state  = S_EVAL;
                end else begin
                    v_adv = 1'b1;
                end
            end

            S_EVAL: begin
                if (w_rec.due > r_tick) begin
                    v_adv = 1'b1;
                end else if (!w_is_task || w_out_free) begin
                    // fire: emit or accumulate, then reschedule or free
                    if (w_is_task) begin
                        n_m_valid = 1'b1;
                        n_m_kind  = RK_TASK;
                        n_m_slot  = w_slot_out;
                        n_m_full  = 1'b0;
                        n_m_task  = w_rec.task_id;
                        n_m_bits  = w_rec.sig;
                        n_m_last  = 1'b0;
                    end else begin
                        n_flags = r_flags | w_rec.sig;
                    end
                    if (!w_is_periodic) begin
                        n_valid[r_idx] = 1'b0;
                        v_adv          = 1'b1;
                    end else if (w_lag < w_per_eff) begin
                        w_ram_we        = 1'b1;
                        w_ram_wdata.due = sat_time(w_fast_sum);
                        v_adv           = 1'b1;
                    end else begin
                        w_div_req.start = 1'b1;
                        n_state         = S_DIV;
                    end
                end
            end

            S_DIV: begin
                // slot data and counter hold steady while the unit runs
                if (w_div_done) begin
                    w_ram_we        = 1'b1;
                    w_ram_wdata.due = sat_time(w_slow_sum);
                    v_adv           = 1'b1;
                end
            end

            S_FLAGS: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = RK_FLAGS;
                    n_m_slot  = '0;
                    n_m_full  = 1'b0;
                    n_m_task  = '0;
                    n_m_bits  = r_flags;
                    n_m_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // step to the next slot of a tick scan
        if (v_adv) begin
            if (w_is_last) begin
                n_state = S_FLAGS;
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = S_SCAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_tick    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_tick    <= n_tick;
            r_m_valid <= n_m_valid;
        end
        r_idx    <= n_idx;
        r_flags  <= n_flags;
        r_in     <= n_in;
        r_m_kind <= n_m_kind;
        r_m_slot <= n_m_slot;
        r_m_full <= n_m_full;
        r_m_task <= n_m_task;
        r_m_bits <= n_m_bits;
        r_m_last <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_m_bits, r_m_task, r_m_full, r_m_slot};
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;

endmodule

>>> verif/timer_expiry_table_checker.sv
// checker for the timer expiry table: keeps its own copy of the slot table,
// predicts every result transaction and compares it with the block's output
// depends on tet_pkg only
module timer_expiry_table_checker
    import tet_pkg::*;
#(
    parameter int TIMER_SLOTS = SLOTS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_tvalid,
    input  logic                  i_in_tready,
    // [1:0] timer_kind, [33:2] first_delay, [65:34] period,
    // [73:66] task_id, [105:74] signal_bits, [111:106] zero
    input  logic [IN_DATA_W-1:0]  i_in_tdata,
    // [0] kind
    input  logic                  i_in_tuser,
    input  logic                  i_out_tvalid,
    input  logic                  i_out_tready,
    // [3:0] slot, [4] table_full, [12:5] target_task, [44:13] raised_bits,
    // [47:45] zero
    input  logic [OUT_DATA_W-1:0] i_out_tdata,
    // [1:0] result_kind
    input  logic [RKIND_W-1:0]    i_out_tuser,
    input  logic                  i_out_tlast,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_full_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_result_kind      rkind;
        logic [SLOT_W-1:0] slot;
        logic              full;
        logic [TASK_W-1:0] target;
        logic [SIG_W-1:0]  bits;
        logic              last;
    } t_timer_result;

    // mirrored table state
    logic [TIME_W-1:0] ticks_now;
    logic              armed [TIMER_SLOTS];
    logic [TIME_W-1:0] due_at [TIMER_SLOTS];
    logic [TIME_W-1:0] period_of [TIMER_SLOTS];
    t_timer_kind       kind_of [TIMER_SLOTS];
    logic [TASK_W-1:0] task_of [TIMER_SLOTS];
    logic [SIG_W-1:0]  signal_of [TIMER_SLOTS];

    t_timer_result awaited_results[$];

    function automatic t_timer_result timer_result(input t_result_kind rk, input int slot,
                                                   input logic full,
                                                   input logic [TASK_W-1:0] target,
                                                   input logic [SIG_W-1:0] bits,
                                                   input logic last);
        t_timer_result r;
        r.rkind  = rk;
        r.slot   = slot[SLOT_W-1:0];
        r.full   = full;
        r.target = target;
        r.bits   = bits;
        r.last   = last;
        return r;
    endfunction

    // first due + k*period beyond the counter, saturating
    function automatic logic [TIME_W-1:0] next_expiry(input logic [TIME_W-1:0] due,
                                                      input logic [TIME_W-1:0] per,
                                                      input logic [TIME_W-1:0] now);
        logic [63:0] step;
        logic [63:0] laps;
        logic [63:0] sum;
        step = (per == '0) ? 64'd1 : {32'd0, per};
        laps = {32'd0, now - due} / step + 64'd1;
        sum  = {32'd0, due} + laps * step;
        return (sum > {32'd0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // add or tick: update the mirrored table and queue the results it causes
    task automatic expire_or_store(input t_in_kind k, input logic [IN_DATA_W-1:0] d);
        t_timer_kind       tk;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] due;
        logic [SIG_W-1:0]  flags;
        int                i;
        int                free_slot;
        tk    = t_timer_kind'(d[1:0]);
        delay = d[33:2];
        if (k == IN_ADD) begin
            due = ticks_now + delay;
            if (due < ticks_now) begin
                due = TIME_MAX;
            end
            free_slot = -1;
            for (i = 0; i < TIMER_SLOTS; i++) begin
                if (!armed[i] && free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot < 0) begin
                awaited_results.push_back(timer_result(RK_ADD, 0, 1'b1, '0, '0, 1'b1));
            end else begin
                armed[free_slot]     = 1'b1;
                kind_of[free_slot]   = tk;
                due_at[free_slot]    = due;
                period_of[free_slot] = d[65:34];
                task_of[free_slot]   = d[73:66];
                signal_of[free_slot] = d[105:74];
                awaited_results.push_back(timer_result(RK_ADD, free_slot, 1'b0, '0, '0, 1'b1));
            end
        end else begin
            if (ticks_now != TIME_MAX) begin
                ticks_now = ticks_now + 1'b1;
            end
            flags = '0;
            for (i = 0; i < TIMER_SLOTS; i++) begin
                if (armed[i] && due_at[i] <= ticks_now) begin
                    if (kind_of[i] == TK_TASK_PERIODIC || kind_of[i] == TK_TASK_SINGLE) begin
                        awaited_results.push_back(timer_result(RK_TASK, i, 1'b0, task_of[i],
                                                               signal_of[i], 1'b0));
                    end else begin
                        flags |= signal_of[i];
                    end
                    if (kind_of[i] == TK_TASK_PERIODIC || kind_of[i] == TK_SYS_PERIODIC) begin
                        due_at[i] = next_expiry(due_at[i], period_of[i], ticks_now);
                    end else begin
                        armed[i] = 1'b0;
                    end
                end
            end
            awaited_results.push_back(timer_result(RK_FLAGS, 0, 1'b0, '0, flags, 1'b1));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_timer_result want;
        if (!i_rst_n) begin
            ticks_now = '0;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                armed[i] = 1'b0;
            end
            awaited_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_full_count = 0;
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transaction with nothing expected: tuser %0h tdata %0h",
                           i_out_tuser, i_out_tdata);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", 32'(want.rkind), 32'(i_out_tuser));
                    check_field("slot", 32'(want.slot), 32'(i_out_tdata[3:0]));
                    check_field("table_full", 32'(want.full), 32'(i_out_tdata[4]));
                    check_field("target_task", 32'(want.target), 32'(i_out_tdata[12:5]));
                    check_field("raised_bits", want.bits, i_out_tdata[44:13]);
                    check_field("last", 32'(want.last), 32'(i_out_tlast));
                    check_field("tdata pad", 32'd0, 32'(i_out_tdata[47:45]));
                    if (want.rkind == RK_ADD && want.full) begin
                        o_full_count++;
                    end
                    o_checked++;
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                expire_or_store(t_in_kind'(i_in_tuser), i_in_tdata);
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

>>> verif/timer_expiry_table_unit_test.sv
// testbench top for the timer expiry table: clock, reset, add/tick stimulus
// and random backpressure; depends on tet_pkg, the block and its checker
module timer_expiry_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tet_pkg::*;

    localparam int SLOT_COUNT = SLOTS_DEFAULT;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [1:0] timer_kind, [33:2] first_delay, [65:34] period,
    // [73:66] task_id, [105:74] signal_bits, [111:106] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [0] kind
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [3:0] slot, [4] table_full, [12:5] target_task, [44:13] raised_bits,
    // [47:45] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [1:0] result_kind
    logic [RKIND_W-1:0]    m_axis_tuser;
    logic                  m_axis_tlast;

    int fail_count;
    int pending;
    int checked;
    int full_count;

    // set for the closing stretch: no gaps on input, no stalls on output
    logic quiet;
    int   adds_sent;
    int   ticks_sent;

    timer_expiry_table_unit #(
        .TIMER_SLOTS (SLOT_COUNT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    timer_expiry_table_checker #(
        .TIMER_SLOTS (SLOT_COUNT)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .i_out_tlast  (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_count (full_count)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit, well above the slowest legal run
    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stall bursts, long ready stretches, none when quiet
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(20, 80)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // one input transaction; entered and left at a falling edge, valid kept
    // high on return so back-to-back transactions need no low cycle
    task automatic offer_item(input t_in_kind k, input t_timer_kind tk,
                              input logic [TIME_W-1:0] first_delay,
                              input logic [TIME_W-1:0] period,
                              input logic [TASK_W-1:0] task_id,
                              input logic [SIG_W-1:0] signal_bits);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = k;
        s_axis_tdata  = {6'd0, signal_bits, task_id, period, first_delay, tk};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (k == IN_ADD) begin
            adds_sent++;
        end else begin
            ticks_sent++;
        end
        @(negedge i_clk);
    endtask

    // tick with noise in the unused fields
    task automatic offer_tick();
        offer_item(IN_TICK, t_timer_kind'($urandom_range(0, 3)), $urandom, $urandom,
                   8'($urandom), $urandom);
    endtask

    // mostly short single timers so the table keeps turning over; periodic
    // and far-future timers are rare since they never leave the table
    task automatic offer_random_timer();
        t_timer_kind       tk;
        logic [TIME_W-1:0] first_delay;
        logic [TIME_W-1:0] period;
        logic [SIG_W-1:0]  signal_bits;
        if ($urandom_range(0, 39) == 0) begin
            tk = $urandom_range(0, 1) ? TK_TASK_PERIODIC : TK_SYS_PERIODIC;
            period = $urandom_range(0, 1) ? 32'($urandom_range(0, 6)) : 32'($urandom);
        end else begin
            tk = $urandom_range(0, 1) ? TK_TASK_SINGLE : TK_SYS_SINGLE;
            period = $urandom;
        end
        first_delay = ($urandom_range(0, 59) == 0) ? 32'($urandom)
                                                    : 32'($urandom_range(0, 24));
        signal_bits = ($urandom_range(0, 15) == 0) ? '0 : 32'($urandom);
        offer_item(IN_ADD, tk, first_delay, period, 8'($urandom), signal_bits);
    endtask

    // hold the input side until every predicted result has come out
    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int                j;
        int                add_pct;
        logic [TASK_W-1:0] task_id;
        logic [SIG_W-1:0]  signal_bits;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = IN_TICK;
        s_axis_tdata  = '0;
        quiet         = 1'b0;
        adds_sent     = 0;
        ticks_sent    = 0;
        add_pct       = 40;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: tick on an empty table gives a bare flags transaction
        offer_tick();
        // fill every slot with an immediate task timer, extremes of id and mask
        for (j = 0; j < SLOT_COUNT; j++) begin
            task_id     = (j == 0) ? 8'h00 : (j == 1) ? 8'hff : 8'($urandom);
            signal_bits = (j == 0) ? 32'h0 : (j == 1) ? 32'hffff_ffff : 32'($urandom);
            offer_item(IN_ADD, TK_TASK_SINGLE, '0, $urandom, task_id, signal_bits);
        end
        // table full: answer carries the full flag and stores nothing
        offer_item(IN_ADD, TK_SYS_SINGLE, '0, '0, 8'h5a, 32'hdead_beef);
        // every slot fires at once: sixteen task signals plus the flags
        offer_tick();
        // zero period acts as one: fires on every later tick
        offer_item(IN_ADD, TK_TASK_PERIODIC, '0, '0, 8'h11, 32'h0000_0001);
        // maximum period: fires once, then the due time saturates
        offer_item(IN_ADD, TK_SYS_PERIODIC, '0, 32'hffff_ffff, 8'hff, 32'h8000_0000);
        // counter plus delay overflows, due time saturates
        offer_item(IN_ADD, TK_SYS_SINGLE, 32'hffff_ffff, 32'hffff_ffff, 8'h00,
                   32'hffff_ffff);
        offer_item(IN_ADD, TK_SYS_SINGLE, 32'd1, '0, 8'h22, 32'h0f0f_0f0f);
        offer_item(IN_ADD, TK_TASK_PERIODIC, 32'd3, 32'd2, 8'h33, 32'h00ff_00ff);
        repeat (4) offer_tick();
        s_axis_tvalid = 1'b0;
        wait_drained();

        // random part in segments of varying add density; a drain midway,
        // and no idling on either side over the closing stretch
        for (j = 0; j < 450; j++) begin
            if (j % 30 == 0) begin
                add_pct = $urandom_range(15, 70);
            end
            if (j == 225) begin
                s_axis_tvalid = 1'b0;
                wait_drained();
            end
            if (j == 390) begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 99) < add_pct) begin
                offer_random_timer();
            end else begin
                offer_tick();
            end
        end
        s_axis_tvalid = 1'b0;

        // settle: wait until everything is out, then keep watching for stray results
        wait_drained();
        repeat (700) @(negedge i_clk);

        $display("covered %0d timer adds (%0d answered table full) and %0d ticks",
                 adds_sent, full_count, ticks_sent);
        $display("%0d result transactions compared field by field", checked);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
